/* rtl/gpe_pkg.sv */
// Shared types, constants and event codes for the gamepad poll event generator.
package gpe_pkg;

  localparam int BUTTON_COUNT = 14;
  localparam int ANALOG_COUNT = 6;
  localparam int NUM_SLOTS    = 1 + 2 * ANALOG_COUNT + BUTTON_COUNT;
  localparam int SLOT_ANALOG0 = 1;
  localparam int SLOT_BUTTON0 = 1 + 2 * ANALOG_COUNT;

  localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
  localparam logic [14:0] TRIGGER_THRESHOLD = 15'd1;

  localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;

  typedef enum logic [2:0] {
    EV_CONNECT    = 3'd0,
    EV_DISCONNECT = 3'd1,
    EV_CHANGE     = 3'd2,
    EV_PRESS      = 3'd3,
    EV_RELEASE    = 3'd4
  } event_type_t;

  // Lane order: LX, LY, RX, RY, left trigger, right trigger.
  localparam logic [4:0] ANALOG_CODE [ANALOG_COUNT] = '{
    5'd16, 5'd17, 5'd18, 5'd19, 5'd14, 5'd15
  };

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  typedef struct packed {
    logic        change;
    logic        press;
    logic        release_ev;
    logic [15:0] next_value;
  } lane_result_t;

  typedef struct packed {
    logic [1:0]                        pad;
    logic                              disc;
    logic [ANALOG_COUNT-1:0]           pressed;
    logic [ANALOG_COUNT-1:0][15:0]     values;
    logic [BUTTON_COUNT-1:0]           buttons;
  } poll_info_t;

  typedef struct packed {
    logic [BUTTON_COUNT-1:0]           buttons;
    logic [ANALOG_COUNT-1:0][15:0]     analog;
  } pad_row_t;

endpackage

/* rtl/gpe_analog_lane.sv */
// One analog control lane: threshold test and change/press/release decision.
module gpe_analog_lane
  import gpe_pkg::*;
(
  input  logic signed [15:0] value,
  input  logic        [15:0] stored,
  input  logic        [14:0] threshold,
  output lane_result_t       result
);

  logic signed [16:0] sv;
  logic signed [16:0] th;
  logic               pressed;

  assign sv      = 17'(value);
  assign th      = signed'({2'b00, threshold});
  assign pressed = (sv >= th) || (sv <= -th);

  always_comb begin
    result.press      = pressed;
    result.change     = pressed && (stored != value);
    result.release_ev = !pressed && (stored != 16'd0);
    result.next_value = pressed ? value : 16'd0;
  end

endmodule

/* rtl/gpe_merge.sv */
// Merge stage: walk the pending event slots in order and drive the output register.
module gpe_merge
  import gpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [NUM_SLOTS-1:0] load_mask,
  input  poll_info_t           info,
  output logic                 pending,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           event_pad,
  output logic [2:0]           event_type,
  output logic [4:0]           control_code,
  output logic signed [15:0]   event_value,
  output logic                 last_of_poll
);

  logic [NUM_SLOTS-1:0] mask;
  logic [4:0]           slot;
  logic [4:0]           sub;
  logic [2:0]           lane;
  logic [3:0]           btn;
  logic                 advance;
  event_type_t          sel_type;
  logic [4:0]           sel_code;
  logic [15:0]          sel_value;
  logic [NUM_SLOTS-1:0] rest;

  assign pending = |mask;
  assign advance = pending && (!out_valid || out_ready);

  // Priority pick of the lowest pending slot.
  always_comb begin
    slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (mask[s]) slot = 5'(s);
    end
  end

  always_comb begin
    rest       = mask;
    rest[slot] = 1'b0;
    sub        = slot - 5'(SLOT_ANALOG0);
    lane       = sub[3:1];
    btn        = 4'(slot - 5'(SLOT_BUTTON0));
    sel_type   = EV_CONNECT;
    sel_code   = {3'b000, info.pad};
    sel_value  = 16'd0;
    if (slot == 5'd0) begin
      sel_type = info.disc ? EV_DISCONNECT : EV_CONNECT;
    end else if (slot < 5'(SLOT_BUTTON0)) begin
      sel_code = ANALOG_CODE[lane];
      if (!sub[0]) begin
        sel_type  = EV_CHANGE;
        sel_value = info.values[lane];
      end else if (info.pressed[lane]) begin
        sel_type  = EV_PRESS;
        sel_value = info.values[lane];
      end else begin
        sel_type = EV_RELEASE;
      end
    end else begin
      sel_code = 5'(btn);
      sel_type = info.buttons[btn] ? EV_PRESS : EV_RELEASE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        mask <= load_mask;
      end else if (advance) begin
        mask <= rest;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_pad    <= info.pad;
      event_type   <= sel_type;
      control_code <= sel_code;
      event_value  <= sel_value;
      last_of_poll <= (rest == '0);
    end
  end

endmodule

/* rtl/gamepad_poll_event_generator.sv */
// Top level of the gamepad poll event generator.
//
// Input channel (in_valid/in_ready) takes one poll snapshot of one controller.
// Output channel (out_valid/out_ready) returns the events caused by that poll,
// one per transfer, in order: connect/disconnect, sticks LX LY RX RY, triggers,
// then the 14 buttons; last_of_poll marks the final event of a poll.
// Configuration channel (cfg_valid/cfg_ready) writes the two stick deadzones;
// it is always ready, and unknown indexes are dropped.
// After its transfer, a poll is judged in the EVAL state and its slot mask is
// loaded into the merge stage, which moves one event per cycle into the output
// register while the receiver does not stall; the next poll is taken as soon
// as the last event has moved into the output register.
// Six analog lanes judge all analog controls of the poll in parallel, and the
// per-pad state row (held buttons, last analog values) is one memory read.
// Reset clears the connected flags and the row valid bits, so every pad reads
// as disconnected with all state zero; deadzones return to their defaults.
// A stalled receiver holds the output register and the merge stage waits.
// Polls for a pad index at or beyond NUM_PADS are taken and produce nothing.
module gamepad_poll_event_generator
  import gpe_pkg::*;
#(
  parameter int NUM_PADS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         pad_index,
  input  logic               pad_present,
  input  logic [13:0]        button_bits,
  input  logic [7:0]         left_trigger,
  input  logic [7:0]         right_trigger,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] left_y,
  input  logic signed [15:0] right_x,
  input  logic signed [15:0] right_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_pad,
  output logic [2:0]         event_type,
  output logic [4:0]         control_code,
  output logic signed [15:0] event_value,
  output logic               last_of_poll,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int PW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  // Configuration registers.
  logic [14:0] left_dz;
  logic [14:0] right_dz;

  // Control.
  state_t state;
  state_t state_next;
  logic   in_xfer;
  logic   pending;
  logic   merge_load;
  logic   in_pad_ok;

  // Latched poll.
  logic [1:0]                        poll_pad;
  logic [PW-1:0]                     poll_sel;
  logic                              poll_present;
  logic                              poll_pad_ok;
  logic [BUTTON_COUNT-1:0]           poll_buttons;
  logic [ANALOG_COUNT-1:0][15:0]     poll_value;
  logic                              poll_disc;
  logic [ANALOG_COUNT-1:0]           poll_pressed;

  // Per-pad state.
  logic [NUM_PADS-1:0] pad_connected;
  logic [NUM_PADS-1:0] row_valid;
  pad_row_t            rows [NUM_PADS];
  pad_row_t            row_rd;
  logic                row_rd_ok;
  logic                conn_rd;
  pad_row_t            row_cur;
  pad_row_t            row_new;

  lane_result_t              lane_res [ANALOG_COUNT];
  logic [14:0]               lane_th  [ANALOG_COUNT];
  logic [NUM_SLOTS-1:0]      eval_mask;
  logic [PW-1:0]             in_sel;
  poll_info_t                info;

  assign cfg_ready = 1'b1;
  assign in_sel    = PW'(pad_index);
  assign in_pad_ok = 32'(pad_index) < NUM_PADS;
  assign in_ready  = (state == ST_IDLE) || (state == ST_EMIT && !pending);
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEFT_DZ:  left_dz  <= cfg_data;
        CFG_RIGHT_DZ: right_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // State machine: take a poll, evaluate it against the stored row, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    merge_load = 1'b0;
    unique case (state)
      ST_IDLE, ST_EMIT: begin
        if (in_xfer) begin
          state_next = in_pad_ok ? ST_EVAL : ST_IDLE;
        end else if (!pending) begin
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        merge_load = 1'b1;
        state_next = (eval_mask != '0) ? ST_EMIT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the poll and read its pad row in the transfer cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      poll_pad      <= pad_index;
      poll_sel      <= in_sel;
      poll_present  <= pad_present;
      poll_pad_ok   <= in_pad_ok;
      poll_buttons  <= button_bits;
      poll_value[0] <= left_x;
      poll_value[1] <= left_y;
      poll_value[2] <= right_x;
      poll_value[3] <= right_y;
      poll_value[4] <= {8'd0, left_trigger};
      poll_value[5] <= {8'd0, right_trigger};
      row_rd        <= rows[in_sel];
      row_rd_ok     <= row_valid[in_sel];
      conn_rd       <= pad_connected[in_sel];
    end
  end

  // A row never written since reset reads as all zero.
  assign row_cur = row_rd_ok ? row_rd : '0;

  // Analog lanes: sticks use their deadzone, triggers count as pressed above zero.
  assign lane_th[0] = left_dz;
  assign lane_th[1] = left_dz;
  assign lane_th[2] = right_dz;
  assign lane_th[3] = right_dz;
  assign lane_th[4] = TRIGGER_THRESHOLD;
  assign lane_th[5] = TRIGGER_THRESHOLD;

  for (genvar j = 0; j < ANALOG_COUNT; j++) begin : g_lane
    gpe_analog_lane u_lane (
      .value     (poll_value[j]),
      .stored    (row_cur.analog[j]),
      .threshold (lane_th[j]),
      .result    (lane_res[j])
    );
  end

  // Build the pending slot mask and the updated row.
  always_comb begin
    eval_mask       = '0;
    row_new.buttons = poll_buttons;
    row_new.analog  = row_cur.analog;
    if (poll_present) begin
      eval_mask[0] = !conn_rd;
      for (int j = 0; j < ANALOG_COUNT; j++) begin
        eval_mask[SLOT_ANALOG0 + 2 * j]     = lane_res[j].change;
        eval_mask[SLOT_ANALOG0 + 2 * j + 1] = lane_res[j].press | lane_res[j].release_ev;
        row_new.analog[j]                   = lane_res[j].next_value;
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        eval_mask[SLOT_BUTTON0 + i] = poll_buttons[i] | row_cur.buttons[i];
      end
    end else begin
      eval_mask[0] = conn_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      poll_disc <= !poll_present;
      for (int j = 0; j < ANALOG_COUNT; j++) begin
        poll_pressed[j] <= lane_res[j].press;
      end
    end
  end

  // Write back: the row only on a present pad, the connected flag always.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL && poll_pad_ok && poll_present) begin
      rows[poll_sel] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      pad_connected <= '0;
    end else if (state == ST_EVAL && poll_pad_ok) begin
      pad_connected[poll_sel] <= poll_present;
      if (poll_present) begin
        row_valid[poll_sel] <= 1'b1;
      end
    end
  end

  always_comb begin
    info.pad     = poll_pad;
    info.disc    = poll_disc;
    info.pressed = poll_pressed;
    info.values  = poll_value;
    info.buttons = poll_buttons;
  end

  gpe_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (merge_load),
    .load_mask    (eval_mask),
    .info         (info),
    .pending      (pending),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_pad    (event_pad),
    .event_type   (event_type),
    .control_code (control_code),
    .event_value  (event_value),
    .last_of_poll (last_of_poll)
  );

endmodule

/* sim/tb_gamepad_poll_event_generator.sv */
// Self-checking testbench for the gamepad poll event generator.
`timescale 1ns / 1ps

module tb_gamepad_poll_event_generator;
  import gpe_pkg::*;

  localparam int PAD_COUNT = 4;
  // Cycles of quiet after the last event before touching the deadzones.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 5;
  localparam int POLLS_PER_PHASE = 70;

  // Register indexes that map to nothing; writes to them must be dropped.
  localparam logic [1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] CFG_UNMAPPED_HI = 2'd3;

  typedef struct {
    logic [1:0]         pad;
    logic               present;
    logic [13:0]        buttons;
    logic [7:0]         ltrig;
    logic [7:0]         rtrig;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } poll_t;

  typedef struct {
    logic [1:0]         pad;
    event_type_t        kind;
    logic [4:0]         code;
    logic signed [15:0] value;
    logic               last;
  } pad_event_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         pad_index = '0;
  logic               pad_present = 1'b0;
  logic [13:0]        button_bits = '0;
  logic [7:0]         left_trigger = '0;
  logic [7:0]         right_trigger = '0;
  logic signed [15:0] left_x = '0;
  logic signed [15:0] left_y = '0;
  logic signed [15:0] right_x = '0;
  logic signed [15:0] right_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         event_pad;
  logic [2:0]         event_type;
  logic [4:0]         control_code;
  logic signed [15:0] event_value;
  logic               last_of_poll;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;

  gamepad_poll_event_generator #(
    .NUM_PADS(PAD_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pad_index    (pad_index),
    .pad_present  (pad_present),
    .button_bits  (button_bits),
    .left_trigger (left_trigger),
    .right_trigger(right_trigger),
    .left_x       (left_x),
    .left_y       (left_y),
    .right_x      (right_x),
    .right_y      (right_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_pad    (event_pad),
    .event_type   (event_type),
    .control_code (control_code),
    .event_value  (event_value),
    .last_of_poll (last_of_poll),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predicted pad state: deadzones, connected flags, held buttons and the last
  // stored value of every analog control. Analog slot order per pad is
  // left trigger, right trigger, LX, LY, RX, RY, so slot id + 14 is the code.
  // ---------------------------------------------------------------------------
  logic [14:0]        left_dz = LEFT_DZ_RESET;
  logic [14:0]        right_dz = RIGHT_DZ_RESET;
  logic               connected_q [PAD_COUNT];
  logic [13:0]        held_q [PAD_COUNT];
  logic signed [15:0] analog_q [PAD_COUNT][ANALOG_COUNT];

  pad_event_t poll_events [$];  // events of the poll being predicted
  pad_event_t event_q [$];      // events still owed by the block, oldest first
  poll_t      pending_polls [$];
  poll_t      recent_poll [PAD_COUNT];

  bit steady = 1'b0;  // suppress all random idling on both sides
  int errors = 0;

  initial begin
    for (int p = 0; p < PAD_COUNT; p++) begin
      connected_q[p] = 1'b0;
      held_q[p] = '0;
      recent_poll[p] = '{default: '0};
      for (int a = 0; a < ANALOG_COUNT; a++) analog_q[p][a] = '0;
    end
  end

  function automatic void note_event(logic [1:0] pad, event_type_t kind, logic [4:0] code,
                                     logic signed [15:0] value);
    pad_event_t ev;
    ev.pad = pad;
    ev.kind = kind;
    ev.code = code;
    ev.value = value;
    ev.last = 1'b0;
    poll_events.push_back(ev);
  endfunction

  // Apply the press/release rules of one analog control and update its slot.
  function automatic void judge_analog(logic [1:0] pad, int id, bit pressed,
                                       logic signed [15:0] value);
    logic [4:0] code;
    code = 5'(BUTTON_COUNT + id);
    if (pressed) begin
      if (analog_q[pad][id] != value) note_event(pad, EV_CHANGE, code, value);
      analog_q[pad][id] = value;
      note_event(pad, EV_PRESS, code, value);
    end else begin
      if (analog_q[pad][id] != 16'sd0) note_event(pad, EV_RELEASE, code, 16'sd0);
      analog_q[pad][id] = '0;
    end
  endfunction

  // Work out every event one accepted poll causes and queue them in order.
  function automatic void predict_poll(poll_t p);
    int stick [4];
    int dz;
    bit pressed;
    poll_events.delete();
    stick[0] = p.lx;
    stick[1] = p.ly;
    stick[2] = p.rx;
    stick[3] = p.ry;
    if (p.pad < PAD_COUNT) begin
      if (!p.present) begin
        // Absent pad: drop the connection, keep buttons and analogs.
        if (connected_q[p.pad]) begin
          connected_q[p.pad] = 1'b0;
          note_event(p.pad, EV_DISCONNECT, 5'(p.pad), 16'sd0);
        end
      end else begin
        if (!connected_q[p.pad]) begin
          connected_q[p.pad] = 1'b1;
          note_event(p.pad, EV_CONNECT, 5'(p.pad), 16'sd0);
        end
        // Sticks: a zero deadzone makes every value count as pressed.
        for (int i = 0; i < 4; i++) begin
          dz = (i < 2) ? int'(left_dz) : int'(right_dz);
          pressed = (stick[i] >= dz) || (stick[i] <= -dz);
          judge_analog(p.pad, 2 + i, pressed, 16'(stick[i]));
        end
        judge_analog(p.pad, 0, p.ltrig != 8'd0, {8'h00, p.ltrig});
        judge_analog(p.pad, 1, p.rtrig != 8'd0, {8'h00, p.rtrig});
        // Buttons: press on every poll while held, release only on falling.
        for (int b = 0; b < BUTTON_COUNT; b++) begin
          if (p.buttons[b]) begin
            held_q[p.pad][b] = 1'b1;
            note_event(p.pad, EV_PRESS, 5'(b), 16'sd0);
          end else begin
            if (held_q[p.pad][b]) note_event(p.pad, EV_RELEASE, 5'(b), 16'sd0);
            held_q[p.pad][b] = 1'b0;
          end
        end
      end
    end
    if (poll_events.size() != 0) poll_events[$].last = 1'b1;
    foreach (poll_events[k]) event_q.push_back(poll_events[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present polls from the pending queue, hold each one until it is
  // transferred, predict its events at the transfer edge.
  // ---------------------------------------------------------------------------
  poll_t cur_poll;

  always @(posedge clk) begin
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_poll(cur_poll);
      // Advance only when the slot is free; otherwise hold valid and payload.
      if (!in_valid || in_ready) begin
        if (pending_polls.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
          nxt = pending_polls.pop_front();
          cur_poll      <= nxt;
          pad_index     <= nxt.pad;
          pad_present   <= nxt.present;
          button_bits   <= nxt.buttons;
          left_trigger  <= nxt.ltrig;
          right_trigger <= nxt.rtrig;
          left_x        <= nxt.lx;
          left_y        <= nxt.ly;
          right_x       <= nxt.rx;
          right_y       <= nxt.ry;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the receiver at random and check each transferred event
  // against the oldest one still owed.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    pad_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event pad %0d type %0d code %0d value %0d",
                                    event_pad, event_type, control_code, event_value));
        end else begin
          want = event_q.pop_front();
          if (event_pad !== want.pad)
            report_mismatch($sformatf("event_pad %0d, want %0d", event_pad, want.pad));
          if (event_type !== want.kind)
            report_mismatch($sformatf("event_type %0d, want %0d (pad %0d code %0d)",
                                      event_type, want.kind, want.pad, want.code));
          if (control_code !== want.code)
            report_mismatch($sformatf("control_code %0d, want %0d (pad %0d type %0d)",
                                      control_code, want.code, want.pad, want.kind));
          if (event_value !== want.value)
            report_mismatch($sformatf("event_value %0d, want %0d (pad %0d code %0d)",
                                      event_value, want.value, want.pad, want.code));
          if (last_of_poll !== want.last)
            report_mismatch($sformatf("last_of_poll %0b, want %0b (pad %0d code %0d)",
                                      last_of_poll, want.last, want.pad, want.code));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog: end the run if no channel has transferred anything for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic poll_t mk_poll(logic [1:0] pad, logic present, logic [13:0] buttons,
                                    logic [7:0] lt, logic [7:0] rt,
                                    logic signed [15:0] lx, logic signed [15:0] ly,
                                    logic signed [15:0] rx, logic signed [15:0] ry);
    poll_t p;
    p.pad = pad;
    p.present = present;
    p.buttons = buttons;
    p.ltrig = lt;
    p.rtrig = rt;
    p.lx = lx;
    p.ly = ly;
    p.rx = rx;
    p.ry = ry;
    return p;
  endfunction

  // Bias stick values toward the deadzone edges, the extremes and repeats.
  function automatic logic signed [15:0] pick_axis(logic signed [15:0] prev, logic [14:0] dz);
    int d;
    d = dz;
    case ($urandom_range(9))
      0:       return 16'sd0;
      1:       return 16'(d);
      2:       return 16'(-d);
      3:       return 16'(d - 1);
      4:       return 16'(1 - d);
      5:       return 16'sh7FFF;
      6:       return 16'sh8000;
      7, 8:    return prev;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger(logic [7:0] prev);
    case ($urandom_range(6))
      0, 1:    return 8'd0;
      2:       return 8'd255;
      3:       return 8'd1;
      4:       return prev;
      default: return 8'($urandom());
    endcase
  endfunction

  // Most polls are of present pads and reuse the pad's last values so that
  // holds, repeats without change and releases all get exercised.
  function automatic poll_t random_poll();
    poll_t p;
    poll_t prev;
    p.pad = 2'($urandom_range(3));
    prev = recent_poll[p.pad];
    p.present = ($urandom_range(99) < 85);
    case ($urandom_range(3))
      0:       p.buttons = prev.buttons;
      1:       p.buttons = 14'($urandom());
      2:       p.buttons = prev.buttons ^ (14'd1 << $urandom_range(BUTTON_COUNT - 1));
      default: p.buttons = '0;
    endcase
    p.ltrig = pick_trigger(prev.ltrig);
    p.rtrig = pick_trigger(prev.rtrig);
    p.lx = pick_axis(prev.lx, left_dz);
    p.ly = pick_axis(prev.ly, left_dz);
    p.rx = pick_axis(prev.rx, right_dz);
    p.ry = pick_axis(prev.ry, right_dz);
    if (p.present) recent_poll[p.pad] = p;
    return p;
  endfunction

  // Wait until every poll is transferred and every event has come back, then
  // let the block settle in case the last poll caused no event at all.
  task automatic drain();
    @(negedge clk);
    while (pending_polls.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [14:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LEFT_DZ) left_dz = data;
    else if (idx == CFG_RIGHT_DZ) right_dz = data;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [14:0] ldz;
    logic [14:0] rdz;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed polls at the reset deadzones (7849 left, 8689 right).
    @(negedge clk);
    // Absent pad that was never connected: nothing.
    pending_polls.push_back(mk_poll(0, 0, 14'($urandom()), 8'($urandom()), 8'($urandom()),
                                    16'($urandom()), 16'($urandom()), 16'($urandom()),
                                    16'($urandom())));
    // Connect only: everything at rest.
    pending_polls.push_back(mk_poll(0, 1, 0, 0, 0, 0, 0, 0, 0));
    // All buttons, full triggers, sticks at full scale, exactly on and just inside the deadzone.
    pending_polls.push_back(mk_poll(0, 1, 14'h3FFF, 255, 255, 16'sh7FFF, -16'sd7849,
                                    16'sd8688, -16'sd8689));
    // Same again: presses only, no change events.
    pending_polls.push_back(mk_poll(0, 1, 14'h3FFF, 255, 255, 16'sh7FFF, -16'sd7849,
                                    16'sd8688, -16'sd8689));
    pending_polls.push_back(mk_poll(0, 1, 14'h1555, 1, 0, 16'sd7848, -16'sd7848,
                                    16'sd8689, 16'sh8000));
    pending_polls.push_back(mk_poll(0, 1, 14'h2AAA, 0, 1, 16'sh8000, 16'sh7FFF,
                                    -16'sd8689, 16'sd0));
    pending_polls.push_back(mk_poll(0, 1, 0, 0, 0, 0, 0, 0, 0));
    // Disconnect, then a second absent poll that says nothing.
    pending_polls.push_back(mk_poll(0, 0, 14'h3FFF, 255, 255, 0, 0, 0, 0));
    pending_polls.push_back(mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Longest poll: connect plus change and press on every analog plus all buttons.
    pending_polls.push_back(mk_poll(3, 1, 14'h3FFF, 255, 255, 16'sh8000, 16'sh8000,
                                    16'sh7FFF, 16'sh7FFF));
    // Absent pad keeps its state, so reconnecting gives presses without changes.
    pending_polls.push_back(mk_poll(3, 0, 14'h1234, 7, 9, 16'sd5, 16'sd6, 16'sd7, 16'sd8));
    pending_polls.push_back(mk_poll(3, 1, 14'h3FFF, 255, 255, 16'sh8000, 16'sh8000,
                                    16'sh7FFF, 16'sh7FFF));
    pending_polls.push_back(mk_poll(3, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_polls.push_back(mk_poll(1, 1, 0, 0, 0, -16'sd7850, 16'sd7849, -16'sd8690,
                                    16'sd8690));
    pending_polls.push_back(mk_poll(1, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_polls.push_back(mk_poll(2, 1, 14'h0001, 0, 0, 0, 0, 0, 0));
    pending_polls.push_back(mk_poll(2, 1, 14'h2000, 0, 0, 0, 0, 0, 0));
    pending_polls.push_back(mk_poll(2, 1, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases, each under its own deadzone setting.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          ldz = 15'd0;
          rdz = 15'd0;
        end
        1: begin
          ldz = 15'h7FFF;
          rdz = 15'h7FFF;
        end
        2: begin
          ldz = 15'd1;
          rdz = 15'h7FFE;
        end
        3: begin
          ldz = 15'($urandom());
          rdz = 15'($urandom());
        end
        default: begin
          ldz = LEFT_DZ_RESET;
          rdz = RIGHT_DZ_RESET;
        end
      endcase
      write_reg(CFG_LEFT_DZ, ldz);
      write_reg(CFG_RIGHT_DZ, rdz);
      // Writes to unmapped indexes must leave both deadzones alone.
      write_reg(CFG_UNMAPPED_LO, 15'($urandom()));
      write_reg(CFG_UNMAPPED_HI, 15'($urandom()));

      @(negedge clk);
      steady = (ph == 2);
      for (int n = 0; n < POLLS_PER_PHASE; n++) pending_polls.push_back(random_poll());
      drain();
      steady = 1'b0;
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
